// ----- design/frm_pkg.sv -----
`default_nettype none

package frm_pkg;

   localparam int UPC_W = 5;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_GCD_INIT,
      OP_GCD_STEP,
      OP_SET_G,
      OP_DIV_NUM,
      OP_DIV_DEN,
      OP_DIV_FIN,
      OP_DIV_STEP,
      OP_NUM_Q,
      OP_DEN_Q,
      OP_MUL_INIT,
      OP_MUL_STEP,
      OP_FOLD_ADD,
      OP_EMIT,
      OP_EMIT_ZDEN
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_DEN_ZERO,
      COND_NUM_ZERO,
      COND_GCD_RUN,
      COND_CNT_RUN,
      COND_NO_FOLD
   } cond_type;

   typedef enum logic [1:0] {
      KIND_ZERO   = 2'd0,
      KIND_WHOLE  = 2'd1,
      KIND_MIXED  = 2'd2,
      KIND_PROPER = 2'd3
   } kind_type;

   localparam logic [UPC_W-1:0] ADR_CHECK        = 5'd0;
   localparam logic [UPC_W-1:0] ADR_GCD_INIT     = 5'd1;
   localparam logic [UPC_W-1:0] ADR_GCD_STEP     = 5'd2;
   localparam logic [UPC_W-1:0] ADR_SET_G        = 5'd3;
   localparam logic [UPC_W-1:0] ADR_DIV_NUM      = 5'd4;
   localparam logic [UPC_W-1:0] ADR_DIV_NUM_LOOP = 5'd5;
   localparam logic [UPC_W-1:0] ADR_NUM_Q        = 5'd6;
   localparam logic [UPC_W-1:0] ADR_DIV_DEN      = 5'd7;
   localparam logic [UPC_W-1:0] ADR_DIV_DEN_LOOP = 5'd8;
   localparam logic [UPC_W-1:0] ADR_DEN_Q        = 5'd9;
   localparam logic [UPC_W-1:0] ADR_FOLD         = 5'd10;
   localparam logic [UPC_W-1:0] ADR_MUL_LOOP     = 5'd11;
   localparam logic [UPC_W-1:0] ADR_FOLD_ADD     = 5'd12;
   localparam logic [UPC_W-1:0] ADR_DIV_FIN      = 5'd13;
   localparam logic [UPC_W-1:0] ADR_DIV_FIN_LOOP = 5'd14;
   localparam logic [UPC_W-1:0] ADR_EMIT         = 5'd15;
   localparam logic [UPC_W-1:0] ADR_EMIT_ZDEN    = 5'd16;

   typedef struct packed {
      op_type             op;
      cond_type           cond;
      logic [UPC_W-1:0]   target;
      logic               last;
   } ucode_word_type;

   typedef struct packed {
      logic den_zero;
      logic num_zero;
      logic gcd_run;
      logic cnt_run;
      logic no_fold;
   } status_type;

   typedef struct packed {
      logic   load;
      logic   exec;
      op_type op;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- design/frm_ucode_rom.sv -----
`default_nettype none

module frm_ucode_rom (
   input  wire logic [frm_pkg::UPC_W-1:0] upc,
   output frm_pkg::ucode_word_type        word
);
   import frm_pkg::*;

   always_comb begin
      unique case (upc)
         ADR_CHECK:        word = '{OP_NOP,       COND_DEN_ZERO, ADR_EMIT_ZDEN,    1'b0};
         ADR_GCD_INIT:     word = '{OP_GCD_INIT,  COND_NUM_ZERO, ADR_FOLD,         1'b0};
         ADR_GCD_STEP:     word = '{OP_GCD_STEP,  COND_GCD_RUN,  ADR_GCD_STEP,     1'b0};
         ADR_SET_G:        word = '{OP_SET_G,     COND_NEVER,    ADR_CHECK,        1'b0};
         ADR_DIV_NUM:      word = '{OP_DIV_NUM,   COND_NEVER,    ADR_CHECK,        1'b0};
         ADR_DIV_NUM_LOOP: word = '{OP_DIV_STEP,  COND_CNT_RUN,  ADR_DIV_NUM_LOOP, 1'b0};
         ADR_NUM_Q:        word = '{OP_NUM_Q,     COND_NEVER,    ADR_CHECK,        1'b0};
         ADR_DIV_DEN:      word = '{OP_DIV_DEN,   COND_NEVER,    ADR_CHECK,        1'b0};
         ADR_DIV_DEN_LOOP: word = '{OP_DIV_STEP,  COND_CNT_RUN,  ADR_DIV_DEN_LOOP, 1'b0};
         ADR_DEN_Q:        word = '{OP_DEN_Q,     COND_NEVER,    ADR_CHECK,        1'b0};
         ADR_FOLD:         word = '{OP_MUL_INIT,  COND_NO_FOLD,  ADR_DIV_FIN,      1'b0};
         ADR_MUL_LOOP:     word = '{OP_MUL_STEP,  COND_CNT_RUN,  ADR_MUL_LOOP,     1'b0};
         ADR_FOLD_ADD:     word = '{OP_FOLD_ADD,  COND_NEVER,    ADR_CHECK,        1'b0};
         ADR_DIV_FIN:      word = '{OP_DIV_FIN,   COND_NEVER,    ADR_CHECK,        1'b0};
         ADR_DIV_FIN_LOOP: word = '{OP_DIV_STEP,  COND_CNT_RUN,  ADR_DIV_FIN_LOOP, 1'b0};
         ADR_EMIT:         word = '{OP_EMIT,      COND_NEVER,    ADR_CHECK,        1'b1};
         ADR_EMIT_ZDEN:    word = '{OP_EMIT_ZDEN, COND_NEVER,    ADR_CHECK,        1'b1};
         default:          word = '{OP_NOP,       COND_NEVER,    ADR_CHECK,        1'b1};
      endcase
   end

endmodule

`default_nettype wire

// ----- design/frm_sequencer.sv -----
`default_nettype none

module frm_sequencer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  frm_pkg::status_type            status,
   input  frm_pkg::ucode_word_type        word,
   output logic [frm_pkg::UPC_W-1:0]      upc,
   output frm_pkg::ctrl_type              ctrl
);
   import frm_pkg::*;

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             stall;
   logic             exec;
   logic             jump;

   assign accept = req_valid && !busy_ff;
   assign stall  = word.last && rsp_valid_ff && !rsp_ready;
   assign exec   = busy_ff && !stall;

   always_comb begin
      unique case (word.cond)
         COND_NEVER:    jump = 1'b0;
         COND_DEN_ZERO: jump = status.den_zero;
         COND_NUM_ZERO: jump = status.num_zero;
         COND_GCD_RUN:  jump = status.gcd_run;
         COND_CNT_RUN:  jump = status.cnt_run;
         COND_NO_FOLD:  jump = status.no_fold;
         default:       jump = 1'b0;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         busy_in = 1'b1;
         upc_in  = ADR_CHECK;
      end else if (exec) begin
         if (word.last) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else if (jump) begin
            upc_in = word.target;
         end else begin
            upc_in = upc_ff + UPC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= ADR_CHECK;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign upc       = upc_ff;
   assign ctrl      = '{accept, exec, word.op};

endmodule

`default_nettype wire

// ----- design/frm_datapath.sv -----
`default_nettype none

module frm_datapath #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                         clock,
   input  frm_pkg::ctrl_type                 ctrl,
   input  wire logic signed [DATA_WIDTH-1:0] numerator_in,
   input  wire logic signed [DATA_WIDTH-1:0] denominator_in,
   input  wire logic signed [DATA_WIDTH-1:0] whole_in,
   output frm_pkg::status_type               status,
   output logic [1:0]                        kind,
   output logic                              negative,
   output logic [DATA_WIDTH-1:0]             whole_part,
   output logic [DATA_WIDTH-1:0]             fraction_numerator,
   output logic [DATA_WIDTH-1:0]             fraction_denominator,
   output logic signed [DATA_WIDTH-1:0]      reduced_numerator,
   output logic signed [DATA_WIDTH-1:0]      reduced_denominator,
   output logic                              zero_denominator
);
   import frm_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH);

   logic [DW-1:0] num_ff, num_in, den_ff, den_in, whole_ff, whole_in_r;
   logic [DW-1:0] a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [CW-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;

   logic [1:0]    kind_ff, kind_in;
   logic          neg_ff, neg_in, zden_ff, zden_in;
   logic [DW-1:0] wp_ff, wp_in, fn_ff, fn_in, fd_ff, fd_in, rn_ff, rn_in, rd_ff, rd_in;

   logic [DW-1:0] mag_num, mag_den, mag_quo_neg, trial;
   logic          trial_ok;

   assign mag_num     = num_ff[DW-1] ? (~num_ff + DW'(1)) : num_ff;
   assign mag_den     = den_ff[DW-1] ? (~den_ff + DW'(1)) : den_ff;
   assign mag_quo_neg = ~quo_ff + DW'(1);
   assign trial       = {rem_ff[DW-2:0], quo_ff[DW-1]};
   assign trial_ok    = trial >= dvs_ff;

   assign status.den_zero = den_ff == '0;
   assign status.num_zero = num_ff == '0;
   assign status.gcd_run  = b_ff != '0;
   assign status.cnt_run  = cnt_ff != CW'(DATA_WIDTH - 1);
   assign status.no_fold  = (whole_ff == '0) || !($signed(num_ff) < $signed(den_ff));

   always_comb begin
      num_in     = num_ff;
      den_in     = den_ff;
      whole_in_r = whole_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      g_in       = g_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dvs_in     = dvs_ff;
      kind_in    = kind_ff;
      neg_in     = neg_ff;
      zden_in    = zden_ff;
      wp_in      = wp_ff;
      fn_in      = fn_ff;
      fd_in      = fd_ff;
      rn_in      = rn_ff;
      rd_in      = rd_ff;
      if (ctrl.load) begin
         num_in     = numerator_in;
         den_in     = denominator_in;
         whole_in_r = whole_in;
      end else if (ctrl.exec) begin
         unique case (ctrl.op)
            OP_NOP: begin
            end
            OP_GCD_INIT: begin
               a_in = mag_num;
               b_in = mag_den;
               k_in = '0;
            end
            OP_GCD_STEP: begin
               if (b_ff != '0) begin
                  priority if (!a_ff[0] && !b_ff[0]) begin
                     a_in = a_ff >> 1;
                     b_in = b_ff >> 1;
                     k_in = k_ff + CW'(1);
                  end else if (!a_ff[0]) begin
                     a_in = a_ff >> 1;
                  end else if (!b_ff[0]) begin
                     b_in = b_ff >> 1;
                  end else if (a_ff > b_ff) begin
                     a_in = a_ff - b_ff;
                  end else begin
                     b_in = b_ff - a_ff;
                  end
               end
            end
            OP_SET_G: begin
               g_in = a_ff << k_ff;
            end
            OP_DIV_NUM: begin
               rem_in = '0;
               quo_in = mag_num;
               dvs_in = g_ff;
               cnt_in = '0;
            end
            OP_DIV_DEN: begin
               rem_in = '0;
               quo_in = mag_den;
               dvs_in = g_ff;
               cnt_in = '0;
            end
            OP_DIV_FIN: begin
               rem_in = '0;
               quo_in = mag_num;
               dvs_in = mag_den;
               cnt_in = '0;
            end
            OP_DIV_STEP: begin
               rem_in = trial_ok ? (trial - dvs_ff) : trial;
               quo_in = {quo_ff[DW-2:0], trial_ok};
               cnt_in = cnt_ff + CW'(1);
            end
            OP_NUM_Q: begin
               num_in = num_ff[DW-1] ? mag_quo_neg : quo_ff;
            end
            OP_DEN_Q: begin
               den_in = den_ff[DW-1] ? mag_quo_neg : quo_ff;
            end
            OP_MUL_INIT: begin
               rem_in = '0;
               quo_in = den_ff;
               dvs_in = whole_ff;
               cnt_in = '0;
            end
            OP_MUL_STEP: begin
               rem_in = quo_ff[0] ? (rem_ff + dvs_ff) : rem_ff;
               dvs_in = dvs_ff << 1;
               quo_in = quo_ff >> 1;
               cnt_in = cnt_ff + CW'(1);
            end
            OP_FOLD_ADD: begin
               num_in = rem_ff + num_ff;
            end
            OP_EMIT: begin
               priority if (num_ff == '0) begin
                  kind_in = KIND_ZERO;
               end else if (quo_ff == '0) begin
                  kind_in = KIND_PROPER;
               end else if (quo_ff == DW'(1) && rem_ff == '0) begin
                  kind_in = KIND_WHOLE;
               end else begin
                  kind_in = KIND_MIXED;
               end
               neg_in  = (num_ff != '0) && (num_ff[DW-1] != den_ff[DW-1]);
               zden_in = 1'b0;
               wp_in   = quo_ff;
               fn_in   = rem_ff;
               fd_in   = mag_den;
               rn_in   = num_ff;
               rd_in   = den_ff;
            end
            OP_EMIT_ZDEN: begin
               kind_in = KIND_ZERO;
               neg_in  = 1'b0;
               zden_in = 1'b1;
               wp_in   = '0;
               fn_in   = '0;
               fd_in   = '0;
               rn_in   = '0;
               rd_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      whole_ff <= whole_in_r;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      g_ff     <= g_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      kind_ff  <= kind_in;
      neg_ff   <= neg_in;
      zden_ff  <= zden_in;
      wp_ff    <= wp_in;
      fn_ff    <= fn_in;
      fd_ff    <= fd_in;
      rn_ff    <= rn_in;
      rd_ff    <= rd_in;
   end

   assign kind                 = kind_ff;
   assign negative             = neg_ff;
   assign whole_part           = wp_ff;
   assign fraction_numerator   = fn_ff;
   assign fraction_denominator = fd_ff;
   assign reduced_numerator    = rn_ff;
   assign reduced_denominator  = rd_ff;
   assign zero_denominator     = zden_ff;

endmodule

`default_nettype wire

// ----- design/fraction_reduce_to_mixed_core.sv -----
// A zero denominator goes straight to the response and a zero numerator skips the binary GCD loop
// and the reductions; otherwise the binary GCD, the reductions and the final division run, with a
// multiply added when the whole part is folded in. One request is processed at a time. The
// micro-program sequencer drives a shared divider that yields one quotient bit per cycle.
// Synchronous reset clears the sequencer and the response valid; payload registers are not reset.
`default_nettype none

module fraction_reduce_to_mixed_core #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [DATA_WIDTH-1:0] req_numerator_in,
   input  wire logic signed [DATA_WIDTH-1:0] req_denominator_in,
   input  wire logic signed [DATA_WIDTH-1:0] req_whole_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [1:0]                        rsp_kind,
   output logic                              rsp_negative,
   output logic [DATA_WIDTH-1:0]             rsp_whole_part,
   output logic [DATA_WIDTH-1:0]             rsp_fraction_numerator,
   output logic [DATA_WIDTH-1:0]             rsp_fraction_denominator,
   output logic signed [DATA_WIDTH-1:0]      rsp_reduced_numerator,
   output logic signed [DATA_WIDTH-1:0]      rsp_reduced_denominator,
   output logic                              rsp_zero_denominator
);
   import frm_pkg::*;

   logic [UPC_W-1:0] upc;
   ucode_word_type   word;
   status_type       status;
   ctrl_type         ctrl;

   frm_ucode_rom u_rom (
      .upc  (upc),
      .word (word)
   );

   frm_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .word      (word),
      .upc       (upc),
      .ctrl      (ctrl)
   );

   frm_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock                (clock),
      .ctrl                 (ctrl),
      .numerator_in         (req_numerator_in),
      .denominator_in       (req_denominator_in),
      .whole_in             (req_whole_in),
      .status               (status),
      .kind                 (rsp_kind),
      .negative             (rsp_negative),
      .whole_part           (rsp_whole_part),
      .fraction_numerator   (rsp_fraction_numerator),
      .fraction_denominator (rsp_fraction_denominator),
      .reduced_numerator    (rsp_reduced_numerator),
      .reduced_denominator  (rsp_reduced_denominator),
      .zero_denominator     (rsp_zero_denominator)
   );

endmodule

`default_nettype wire

// ----- design/frm_checker.sv -----
`default_nettype none

module frm_checker #(
   parameter int DATA_WIDTH = 32
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic signed [DATA_WIDTH-1:0] req_numerator_in,
   input wire logic signed [DATA_WIDTH-1:0] req_denominator_in,
   input wire logic signed [DATA_WIDTH-1:0] req_whole_in,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [1:0]                   rsp_kind,
   input wire logic                         rsp_negative,
   input wire logic [DATA_WIDTH-1:0]        rsp_whole_part,
   input wire logic [DATA_WIDTH-1:0]        rsp_fraction_numerator,
   input wire logic [DATA_WIDTH-1:0]        rsp_fraction_denominator,
   input wire logic signed [DATA_WIDTH-1:0] rsp_reduced_numerator,
   input wire logic signed [DATA_WIDTH-1:0] rsp_reduced_denominator,
   input wire logic                         rsp_zero_denominator
);
   import frm_pkg::*;

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_whole_part) && $stable(rsp_reduced_numerator))
      else $error("response changed while stalled");

   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_denominator |-> rsp_kind == KIND_ZERO && !rsp_negative &&
         rsp_whole_part == '0 && rsp_fraction_denominator == '0 &&
         rsp_reduced_numerator == '0)
      else $error("zero denominator response carries data");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_denominator |-> rsp_fraction_denominator != '0 &&
         rsp_reduced_denominator != '0)
      else $error("reduced denominator is zero");

   a_zero_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_denominator && rsp_kind == KIND_ZERO |->
         !rsp_negative && rsp_whole_part == '0 && rsp_fraction_numerator == '0)
      else $error("zero result carries a magnitude");

endmodule

bind fraction_reduce_to_mixed_core frm_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (.*);

`default_nettype wire

// ----- test/fraction_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none

module fraction_checker #(
   parameter int DW = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic signed [DW-1:0] req_numerator_in,
   input  wire logic signed [DW-1:0] req_denominator_in,
   input  wire logic signed [DW-1:0] req_whole_in,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [1:0]           rsp_kind,
   input  wire logic                 rsp_negative,
   input  wire logic [DW-1:0]        rsp_whole_part,
   input  wire logic [DW-1:0]        rsp_fraction_numerator,
   input  wire logic [DW-1:0]        rsp_fraction_denominator,
   input  wire logic signed [DW-1:0] rsp_reduced_numerator,
   input  wire logic signed [DW-1:0] rsp_reduced_denominator,
   input  wire logic                 rsp_zero_denominator,
   output int                        outstanding,
   output int                        fail_count
);
   import frm_pkg::*;

   typedef struct packed {
      kind_type          kind;
      logic              negative;
      logic [DW-1:0]     whole_part;
      logic [DW-1:0]     frac_num;
      logic [DW-1:0]     frac_den;
      logic [DW-1:0]     red_num;
      logic [DW-1:0]     red_den;
      logic              zero_den;
   } mixed_number_type;

   mixed_number_type mixed_q[$];
   mixed_number_type want;
   int               mismatches = 0;

   function automatic mixed_number_type reduce_to_mixed(logic [DW-1:0] num_in,
                                                        logic [DW-1:0] den_in,
                                                        logic [DW-1:0] whole_in);
      mixed_number_type r;
      logic [DW-1:0] num, den, mag_n, mag_d, a, b, t;
      logic          sn, sd;
      r   = '0;
      num = num_in;
      den = den_in;
      if (den == '0) begin
         r.zero_den = 1'b1;
         return r;
      end
      if (num != '0) begin
         sn    = num[DW-1];
         sd    = den[DW-1];
         mag_n = sn ? -num : num;
         mag_d = sd ? -den : den;
         a     = mag_n;
         b     = mag_d;
         while (b != '0) begin
            t = a % b;
            a = b;
            b = t;
         end
         mag_n = mag_n / a;
         mag_d = mag_d / a;
         num   = sn ? -mag_n : mag_n;
         den   = sd ? -mag_d : mag_d;
      end
      if (whole_in != '0 && $signed(num) < $signed(den)) begin
         num = whole_in * den + num;
      end
      mag_n      = num[DW-1] ? -num : num;
      mag_d      = den[DW-1] ? -den : den;
      r.negative = (num != '0) && (num[DW-1] != den[DW-1]);
      r.frac_den = mag_d;
      r.red_num  = num;
      r.red_den  = den;
      if (num == '0) begin
         r.kind = KIND_ZERO;
      end else if (mag_n == mag_d) begin
         r.kind       = KIND_WHOLE;
         r.whole_part = mag_n / mag_d;
      end else if (mag_n > mag_d) begin
         r.kind       = KIND_MIXED;
         r.whole_part = mag_n / mag_d;
         r.frac_num   = mag_n % mag_d;
      end else begin
         r.kind     = KIND_PROPER;
         r.frac_num = mag_n;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [DW-1:0] expected, logic [DW-1:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0h, got %0h", name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            mixed_q.push_back(reduce_to_mixed(req_numerator_in, req_denominator_in,
                                              req_whole_in));
         end
         if (rsp_valid && rsp_ready) begin
            if (mixed_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = mixed_q.pop_front();
               check_field("kind", DW'(want.kind), DW'(rsp_kind));
               check_field("negative", DW'(want.negative), DW'(rsp_negative));
               check_field("whole_part", want.whole_part, rsp_whole_part);
               check_field("fraction_numerator", want.frac_num, rsp_fraction_numerator);
               check_field("fraction_denominator", want.frac_den, rsp_fraction_denominator);
               check_field("reduced_numerator", want.red_num, rsp_reduced_numerator);
               check_field("reduced_denominator", want.red_den, rsp_reduced_denominator);
               check_field("zero_denominator", DW'(want.zero_den), DW'(rsp_zero_denominator));
            end
         end
      end
      outstanding <= mixed_q.size();
      fail_count  <= mismatches;
   end

endmodule

`default_nettype wire

// ----- test/tb_fraction_reduce_to_mixed_core.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_fraction_reduce_to_mixed_core;

   localparam int DW             = 32;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int HOLD_CYCLES    = 3000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 400;

   localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINUS_ONE = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 rsp_ready = 1'b0;
   logic signed [DW-1:0] req_numerator_in = '0;
   logic signed [DW-1:0] req_denominator_in = '0;
   logic signed [DW-1:0] req_whole_in = '0;

   wire logic                 req_ready;
   wire logic                 rsp_valid;
   wire logic [1:0]           rsp_kind;
   wire logic                 rsp_negative;
   wire logic [DW-1:0]        rsp_whole_part;
   wire logic [DW-1:0]        rsp_fraction_numerator;
   wire logic [DW-1:0]        rsp_fraction_denominator;
   wire logic signed [DW-1:0] rsp_reduced_numerator;
   wire logic signed [DW-1:0] rsp_reduced_denominator;
   wire logic                 rsp_zero_denominator;

   int outstanding;
   int fail_count;
   int requests_sent = 0;
   int responses_taken = 0;
   int idle_cycles = 0;

   fraction_reduce_to_mixed_core #(.DATA_WIDTH(DW)) dut (.*);

   fraction_checker #(.DW(DW)) u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic logic [DW-1:0] pick_operand();
      logic [DW-1:0] v;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0:       v = MOST_NEG;
               1:       v = MOST_POS;
               2:       v = MINUS_ONE;
               default: v = 1;
            endcase
         end
         1, 2: begin
            v = $urandom_range(1, 64);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_request(logic [DW-1:0] num, logic [DW-1:0] den, logic [DW-1:0] whole);
      int gap;
      gap = ((requests_sent / 250) % 3 == 2) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_numerator_in   <= num;
      req_denominator_in <= den;
      req_whole_in       <= whole;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic run_random(int count);
      logic [DW-1:0] num, den, whole, g, a, b;
      int            sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 3) begin
            num = pick_operand();
            den = '0;
         end else if (sel < 40) begin
            g   = $urandom_range(1, 4000);
            a   = $urandom_range(1, 3000);
            b   = $urandom_range(1, 3000);
            num = $urandom_range(0, 1) ? -(a * g) : a * g;
            den = $urandom_range(0, 1) ? -(b * g) : b * g;
         end else begin
            num = pick_operand();
            den = pick_operand();
         end
         if (sel >= 3 && $urandom_range(0, 19) == 0) num = '0;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: whole = '0;
            4, 5, 6: begin
               whole = $urandom_range(1, 20);
               if ($urandom_range(0, 1)) whole = -whole;
            end
            7, 8: whole = $urandom;
            default: begin
               case ($urandom_range(0, 2))
                  0:       whole = MOST_NEG;
                  1:       whole = MOST_POS;
                  default: whole = MINUS_ONE;
               endcase
            end
         endcase
         send_request(num, den, whole);
      end
   endtask

   // The receiver holds off once for a long stretch so that the block backs up into the request channel;
   // otherwise it waits a random number of cycles per response, but none in every third run of 150.
   initial begin
      int  gap;
      bit  held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (responses_taken == 60 && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = ((responses_taken / 150) % 3 == 1) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         responses_taken++;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(7, '0, '0);
      send_request(MOST_NEG, '0, 5);
      send_request('0, 7, '0);
      send_request('0, 5, 3);
      send_request('0, -5, 3);
      send_request(6, 3, '0);
      send_request(-6, 4, '0);
      send_request(2, 6, '0);
      send_request(3, -9, '0);
      send_request(MOST_NEG, MOST_NEG, '0);
      send_request(MOST_NEG, 1, '0);
      send_request(MOST_NEG, MINUS_ONE, '0);
      send_request(1, MOST_NEG, '0);
      send_request(MOST_POS, MOST_NEG, '0);
      send_request(MOST_POS, MOST_POS, MOST_POS);
      send_request(MINUS_ONE, MINUS_ONE, MOST_NEG);
      send_request(1, 3, 2);
      send_request(1, 3, -2);
      send_request(1, 2, MOST_POS);
      send_request(1, 3, 32'h5555_5555);
      send_request(-5, 1, 3);
      send_request(5, 3, 7);
      send_request(1, -3, 4);
      send_request(-4, -3, 2);
      send_request(MOST_POS, 3, MINUS_ONE);
      wait_drained();

      run_random(RANDOM_ITEMS / 2);
      wait_drained();
      run_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
